// ----- hdl/opl_command_stream_decoder_core_macros.svh -----
// Assertion macros for the checker of the command stream decoder.
`ifndef OPL_COMMAND_STREAM_DECODER_CORE_MACROS_SVH
`define OPL_COMMAND_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OPL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("opl: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OPL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("opl: next-cycle check failed");

`endif

// ----- hdl/opl_pkg.sv -----
// Types and constants of the command stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package opl_pkg;

  // Register numbers with a special meaning in pair mode.
  localparam logic [7:0] RegDelay = 8'h00;
  localparam logic [7:0] RegSpeed = 8'h02;
  localparam logic [7:0] RegEnd   = 8'hFF;
  // Byte value that marks the end of the song.
  localparam logic [7:0] EndByte  = 8'hFF;
  localparam logic [7:0] ZeroByte = 8'h00;

  // Stream formats.
  localparam logic FmtPair   = 1'b0;
  localparam logic FmtRecord = 1'b1;

  // Position of a byte within the current command.
  typedef enum logic [1:0] {
    PhFirst  = 2'd0,
    PhSecond = 2'd1,
    PhThird  = 2'd2,
    PhFourth = 2'd3
  } opl_phase_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       stream_end;
  } opl_in_t;

  typedef struct packed {
    logic        write_valid;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_data;
    logic [15:0] delay_ticks;
    logic        speed_valid;
    logic [15:0] speed_divisor;
    logic        song_end;
  } opl_out_t;

  typedef struct packed {
    opl_phase_e byte_phase;
    logic [7:0] held_first;
    logic [7:0] held_second;
    logic [7:0] held_third;
    logic       speed_capture;
    logic       song_ended;
  } opl_state_t;

endpackage

`default_nettype wire

// ----- hdl/opl_dec.sv -----
// Combinational decode of one stream byte against the current command state.
`timescale 1ns / 1ps
`default_nettype none

module opl_dec (
  input  opl_pkg::opl_state_t state_q_i,
  input  logic                fmt_i,
  input  opl_pkg::opl_in_t    item_i,
  output opl_pkg::opl_state_t state_d_o,
  output logic                res_valid_o,
  output opl_pkg::opl_out_t   res_o
);
  import opl_pkg::*;

  logic [7:0] b;
  assign b = item_i.byte_value;

  always_comb begin
    state_d_o   = state_q_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (!state_q_i.song_ended) begin
      if (item_i.stream_end) begin
        // Any partly collected command or divisor is dropped.
        state_d_o.song_ended    = 1'b1;
        state_d_o.byte_phase    = PhFirst;
        state_d_o.speed_capture = 1'b0;
        res_o.song_end          = 1'b1;
        res_valid_o             = 1'b1;
      end else if (fmt_i == FmtPair) begin
        if (state_q_i.byte_phase == PhFirst) begin
          state_d_o.held_first = b;
          state_d_o.byte_phase = PhSecond;
        end else if (state_q_i.speed_capture) begin
          state_d_o.speed_capture = 1'b0;
          state_d_o.byte_phase    = PhFirst;
          res_o.speed_valid       = 1'b1;
          res_o.speed_divisor     = {b, state_q_i.held_first};
          res_valid_o             = 1'b1;
        end else begin
          // The held byte is the data, this byte is the register.
          state_d_o.byte_phase = PhFirst;
          case (b)
            RegDelay: begin
              if (state_q_i.held_first != ZeroByte) begin
                res_o.delay_ticks = {ZeroByte, state_q_i.held_first};
                res_valid_o       = 1'b1;
              end
            end
            RegSpeed: begin
              if (state_q_i.held_first == ZeroByte) begin
                state_d_o.speed_capture = 1'b1;
              end
            end
            RegEnd: begin
              if (state_q_i.held_first == EndByte) begin
                state_d_o.song_ended = 1'b1;
                res_o.song_end       = 1'b1;
                res_valid_o          = 1'b1;
              end
            end
            default: begin
              res_o.write_valid = 1'b1;
              res_o.reg_addr    = b;
              res_o.reg_data    = state_q_i.held_first;
              res_valid_o       = 1'b1;
            end
          endcase
        end
      end else begin
        case (state_q_i.byte_phase)
          PhFirst: begin
            state_d_o.held_first = b;
            state_d_o.byte_phase = PhSecond;
          end
          PhSecond: begin
            state_d_o.held_second = b;
            state_d_o.byte_phase  = PhThird;
          end
          PhThird: begin
            state_d_o.held_third = b;
            state_d_o.byte_phase = PhFourth;
          end
          default: begin
            state_d_o.byte_phase = PhFirst;
            res_valid_o          = 1'b1;
            if (state_q_i.held_first == EndByte && state_q_i.held_second == EndByte &&
                state_q_i.held_third == EndByte && b == EndByte) begin
              state_d_o.song_ended = 1'b1;
              res_o.song_end       = 1'b1;
            end else begin
              res_o.write_valid = 1'b1;
              res_o.reg_addr    = state_q_i.held_first;
              res_o.reg_data    = state_q_i.held_second;
              res_o.delay_ticks = {b, state_q_i.held_third};
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/opl_command_stream_decoder_core.sv -----
// Top level of the recorded synth register stream decoder.
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid_i/in_ready_o   in_data_i  (opl_in_t)
//   out       output     out_valid_o/out_ready_i out_data_o (opl_out_t)
//   cfg       input      cfg_we_i, no wait       cfg_data_i (stream format)
//
// One byte is accepted per cycle while the output is not stalled; a result
// appears in the output register the cycle after the byte that completes
// a command. The next byte is taken while a result waits, as long as that
// result is taken in the same cycle; a stalled output holds back the input.
// Reset clears the command state, the format and the output register.
`timescale 1ns / 1ps
`default_nettype none

module opl_command_stream_decoder_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  opl_pkg::opl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output opl_pkg::opl_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i
);
  import opl_pkg::*;

  opl_state_t state_q, state_d;
  logic       fmt_q;
  logic       res_valid;
  opl_out_t   res;
  logic       out_valid_q;
  opl_out_t   out_data_q;
  logic       in_acc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  opl_dec u_dec (
    .state_q_i   (state_q),
    .fmt_i       (fmt_q),
    .item_i      (in_data_i),
    .state_d_o   (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      fmt_q   <= FmtPair;
    end else if (cfg_we_i) begin
      // A format change drops any partly collected command.
      fmt_q                 <= cfg_data_i;
      state_q.byte_phase    <= PhFirst;
      state_q.speed_capture <= 1'b0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_data_q <= '0;
    end else if (in_acc && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- hdl/opl_chk.sv -----
// Port-level checker for the stream decoder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "opl_command_stream_decoder_core_macros.svh"

module opl_chk (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire opl_pkg::opl_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire opl_pkg::opl_out_t out_data_o,
  input wire logic              cfg_we_i,
  input wire logic              cfg_data_i
);
  import opl_pkg::*;

  logic ended_q;

  // Set once the end-of-song transaction has left the block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && out_data_o.song_end) begin
      ended_q <= 1'b1;
    end
  end

  `OPL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_data_o))
  `OPL_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `OPL_ASSERT_IMPL(a_silent_after_end, clk_i, rst_ni, ended_q, !out_valid_o)
  `OPL_ASSERT_IMPL(a_end_alone, clk_i, rst_ni, out_valid_o && out_data_o.song_end,
                   !out_data_o.write_valid && !out_data_o.speed_valid &&
                   out_data_o.delay_ticks == 16'h0000)
  `OPL_ASSERT_IMPL(a_unused_zero, clk_i, rst_ni, out_valid_o && !out_data_o.write_valid,
                   out_data_o.reg_addr == ZeroByte && out_data_o.reg_data == ZeroByte)

  // The configuration inputs and the input payload are seen but not checked.
  logic unused_inputs;
  assign unused_inputs = in_valid_i ^ cfg_we_i ^ cfg_data_i ^ (^in_data_i);

endmodule

bind opl_command_stream_decoder_core opl_chk u_opl_chk (.*);

`default_nettype wire
